// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg: shared definitions of the text console character engine
// screen geometry, field widths, command and character codes, payload and
// controller/datapath interface structs, cell address helper
// ----------------------------------------------------------------------------
package tcce_pkg;

  // screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_WIDTH   = 8;
  localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;

  // internal widths that follow from the geometry
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLS + 1);

  // interface field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int CROW_W = 5;
  localparam int CCOL_W = 7;
  localparam int LIN_W  = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;
  } tcce_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [CROW_W-1:0] cursor_row;
    logic [CCOL_W-1:0] cursor_col;
    logic [LIN_W-1:0]  cursor_linear;
  } tcce_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic load_out;
  } tcce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_req;
    logic sweep_last;
  } tcce_stat_t;

  // physical row and column to cell memory address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(prow) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col));
  endfunction

endpackage

// ===== rtl/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram: generic single-port ram
// one access per cycle, write or read, read data registered
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcce_ctrl: sequencing controller of the text console character engine
// takes a request, runs it on the datapath, walks blanking sweeps and hands
// the result to the output register
// ----------------------------------------------------------------------------
module tcce_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tcce_pkg::tcce_stat_t stat_i,
  output tcce_pkg::tcce_cmd_t  cmd_o
);
  import tcce_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.sweep_req ? ST_SWEEP : ST_FINISH;
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tcce_dp.sv =====
// ----------------------------------------------------------------------------
// tcce_dp: datapath of the text console character engine
// cursor, scroll offset and attribute registers, cell memory, sweep counter
// and the output register
// ----------------------------------------------------------------------------
module tcce_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcce_pkg::tcce_in_t            in_item_i,
  input  logic                          cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0]   cfg_data_i,
  input  tcce_pkg::tcce_cmd_t           cmd_i,
  output tcce_pkg::tcce_stat_t          stat_o,
  output tcce_pkg::tcce_out_t           out_item_o
);
  import tcce_pkg::*;

  tcce_in_t          item_q;
  tcce_out_t         out_q;
  logic [ATTR_W-1:0] attr_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  off_q;
  logic [ADDR_W-1:0] cnt_q, base_q, last_q;
  logic              hit_q;

  logic [ROW_W:0]    r_v;
  logic [COL_W:0]    c_v;
  logic [ROW_W:0]    st_lrow;
  logic [COL_W-1:0]  st_col;
  logic [CHAR_W-1:0] st_char;
  logic              st_en, st_ok, scroll;
  logic [ADDR_W-1:0] st_addr, rd_addr;
  logic              rd_hit;
  logic [ROW_W-1:0]  off_next;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // logical row plus scroll offset, modulo the screen height
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] off);
    logic [ROW_W:0] s;
    s = {1'b0, lrow} + {1'b0, off};
    if (s >= (ROW_W + 1)'(SCREEN_ROWS)) begin
      s = s - (ROW_W + 1)'(SCREEN_ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  // cursor movement and cell store of a put
  always_comb begin
    r_v     = {1'b0, row_q};
    c_v     = {1'b0, col_q};
    st_en   = 1'b0;
    st_lrow = {1'b0, row_q};
    st_col  = col_q;
    st_char = item_q.char_code;
    if (item_q.char_code == CH_BS) begin
      st_char = CH_SPACE;
      if (c_v != '0) begin
        c_v    = c_v - 1'b1;
        st_en  = 1'b1;
        st_col = c_v[COL_W-1:0];
      end
      if (r_v != '0 && c_v == '0) begin
        r_v = r_v - 1'b1;
        c_v = (COL_W + 1)'(SCREEN_COLS);
      end
    end else if (item_q.char_code == CH_TAB) begin
      c_v = (COL_W + 1)'((c_v / TAB_WIDTH + 1) * TAB_WIDTH);
    end else if (item_q.char_code == CH_CR) begin
      c_v = '0;
    end else if (item_q.char_code == CH_LF) begin
      c_v = '0;
      r_v = r_v + 1'b1;
    end else if (item_q.char_code >= CH_SPACE) begin
      st_en = 1'b1;
      // column past the edge stores at column 0 of the next row
      if (c_v == (COL_W + 1)'(SCREEN_COLS)) begin
        st_lrow = r_v + 1'b1;
        st_col  = '0;
      end
      c_v = c_v + 1'b1;
    end
    if (item_q.char_code != CH_BS && c_v >= (COL_W + 1)'(SCREEN_COLS)) begin
      c_v = '0;
      r_v = r_v + 1'b1;
    end
    scroll = (r_v >= (ROW_W + 1)'(SCREEN_ROWS));
    if (scroll) begin
      r_v = (ROW_W + 1)'(SCREEN_ROWS - 1);
    end
  end

  assign st_ok    = st_en && (st_lrow < (ROW_W + 1)'(SCREEN_ROWS));
  assign st_addr  = cell_addr(phys_row(st_lrow[ROW_W-1:0], off_q), st_col);
  assign rd_hit   = (item_q.command == CMD_READ)
                 && (int'(item_q.read_row) < SCREEN_ROWS)
                 && (int'(item_q.read_col) < SCREEN_COLS);
  assign rd_addr  = cell_addr(phys_row(ROW_W'(item_q.read_row), off_q),
                              COL_W'(item_q.read_col));
  assign off_next = (off_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : off_q + 1'b1;

  assign stat_o.sweep_req  = (item_q.command == CMD_CLEAR)
                          || (item_q.command == CMD_PUT && scroll);
  assign stat_o.sweep_last = (cnt_q == last_q);

  // single memory port: one cell write or read per cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = base_q + cnt_q;
    ram_wdata = {attr_q, CH_SPACE};
    if (cmd_i.exec) begin
      if (item_q.command == CMD_PUT) begin
        ram_we    = st_ok;
        ram_addr  = st_addr;
        ram_wdata = {attr_q, st_char};
      end else if (item_q.command == CMD_READ) begin
        ram_re   = rd_hit;
        ram_addr = rd_addr;
      end
    end else if (cmd_i.sweep) begin
      ram_we = 1'b1;
    end
  end

  tcce_ram #(
    .Width(CELL_W),
    .Depth(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
      row_q  <= '0;
      col_q  <= '0;
      off_q  <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        hit_q <= rd_hit;
        if (item_q.command == CMD_PUT) begin
          row_q <= r_v[ROW_W-1:0];
          col_q <= c_v[COL_W-1:0];
          if (scroll) begin
            off_q <= off_next;
          end
        end else if (item_q.command == CMD_CLEAR) begin
          row_q <= '0;
          col_q <= '0;
          off_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      cnt_q <= '0;
      if (item_q.command == CMD_CLEAR) begin
        base_q <= '0;
        last_q <= ADDR_W'(CELLS - 1);
      end else begin
        // top physical row leaves the screen
        base_q <= cell_addr(off_q, '0);
        last_q <= ADDR_W'(SCREEN_COLS - 1);
      end
    end else if (cmd_i.sweep) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q.cell_data     <= hit_q ? ram_rdata : '0;
      out_q.cursor_row    <= CROW_W'(row_q);
      out_q.cursor_col    <= CCOL_W'(col_q);
      out_q.cursor_linear <= LIN_W'(int'(row_q) * SCREEN_COLS + int'(col_q));
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== rtl/text_console_char_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine: 80x25 text console with cursor and scrolling
// keeps a screen of 16-bit cells (character in the low byte, attribute in the
// high byte), puts characters, clears the screen and reads single cells
// ----------------------------------------------------------------------------
// Each request gives one result: the cell read (read command only, else zero)
// and the cursor after the request as row, column and linear position
// row*80+col, the value for the cursor location registers. A request runs
// through execute and result hand-over, and the next request is taken only
// after the previous result is loaded into the output register. A put that
// scrolls also blanks the top row and a clear blanks the whole screen in a
// sweep, as the single-port cell memory blanks one cell per cycle. A result
// still waiting at the output holds the next one back until it is taken. The
// cell memory is not initialised at reset: issue a clear before reading cells.
// The attribute register may only be written while no request is in flight.
module text_console_char_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tcce_pkg::tcce_in_t          in_item_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tcce_pkg::tcce_out_t         out_item_o,
  // attribute register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_data_i
);
  import tcce_pkg::*;

  tcce_cmd_t  cmd;
  tcce_stat_t stat;

  // attribute writes are always taken, single register so no index
  assign cfg_ready_o = 1'b1;

  // controller: idle, execute, optional blanking sweep, result hand-over
  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: cursor logic, rotating top-row offset, cell memory, output register
  tcce_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_item_o(out_item_o)
  );

`ifndef ASSERT_OFF
  // a captured request is executed on the next cycle
  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.exec)
    else $error("captured request not executed");

  // datapath commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.exec, cmd.sweep, cmd.load_out}))
    else $error("overlapping datapath commands");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd.load_out)
    else $error("pending result overwritten");

  // a loaded result is valid and its cursor row is on the screen
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o && (int'(out_item_o.cursor_row) < SCREEN_ROWS))
    else $error("loaded result invalid or cursor row off screen");
`endif

endmodule

// ===== tb/text_console_char_engine_checker.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine_checker: screen and cursor predictor with checker
// tracks every accepted request and attribute write, works out the cursor
// report and cell read that each request should give, compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_char_engine_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  tcce_pkg::tcce_in_t          in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  tcce_pkg::tcce_out_t         out_item_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_data_i,
  output int                          failures_o,
  output int                          pending_o
);
  import tcce_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // predicted console state
  logic [CELL_W-1:0] screen_mem [CELLS];
  logic [ATTR_W-1:0] attr_q;
  int                top_row;
  int                cur_row;
  int                cur_col;

  tcce_out_t         cursor_reports_q [$];
  int                fail_count;

  // logical linear position to the rotated screen store, dropped past the end
  function automatic void store_logical(input int lin, input logic [CELL_W-1:0] value);
    int lrow;
    int col;
    lrow = lin / SCREEN_COLS;
    col  = lin % SCREEN_COLS;
    if (lrow < SCREEN_ROWS) begin
      screen_mem[((lrow + top_row) % SCREEN_ROWS) * SCREEN_COLS + col] = value;
    end
  endfunction

  function automatic void put_byte(input logic [CHAR_W-1:0] ch);
    int base;
    if (ch == CH_BS) begin
      if (cur_col != 0) begin
        cur_col--;
        store_logical(cur_row * SCREEN_COLS + cur_col, {attr_q, CH_SPACE});
      end
      // steps back onto column 80 of the row above
      if (cur_row > 0 && cur_col == 0) begin
        cur_row--;
        cur_col = SCREEN_COLS;
      end
    end else if (ch == CH_TAB) begin
      cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
    end else if (ch == CH_CR) begin
      cur_col = 0;
    end else if (ch == CH_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (ch >= CH_SPACE) begin
      store_logical(cur_row * SCREEN_COLS + cur_col, {attr_q, ch});
      cur_col++;
    end
    if (cur_col >= SCREEN_COLS && ch != CH_BS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= SCREEN_ROWS) begin
      base = top_row * SCREEN_COLS;
      for (int c = 0; c < SCREEN_COLS; c++) begin
        screen_mem[base + c] = {attr_q, CH_SPACE};
      end
      top_row = (top_row + 1) % SCREEN_ROWS;
      cur_row = SCREEN_ROWS - 1;
    end
  endfunction

  function automatic tcce_out_t apply_console_request(input tcce_in_t req);
    tcce_out_t rep;
    rep = '0;
    case (req.command)
      CMD_PUT: begin
        put_byte(req.char_code);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_mem[i] = {attr_q, CH_SPACE};
        end
        top_row = 0;
        cur_row = 0;
        cur_col = 0;
      end
      CMD_READ: begin
        if (int'(req.read_row) < SCREEN_ROWS && int'(req.read_col) < SCREEN_COLS) begin
          rep.cell_data = screen_mem[((int'(req.read_row) + top_row) % SCREEN_ROWS)
                                     * SCREEN_COLS + int'(req.read_col)];
        end
      end
      default: begin
      end
    endcase
    rep.cursor_row    = CROW_W'(cur_row);
    rep.cursor_col    = CCOL_W'(cur_col);
    rep.cursor_linear = LIN_W'(cur_row * SCREEN_COLS + cur_col);
    return rep;
  endfunction

  function automatic void note_failure();
    fail_count++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tcce_out_t want;
    if (!rst_ni) begin
      attr_q     = ATTR_RESET;
      top_row    = 0;
      cur_row    = 0;
      cur_col    = 0;
      fail_count = 0;
      cursor_reports_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        attr_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (cursor_reports_q.size() == 0) begin
          note_failure();
          if (fail_count <= REPORT_LIMIT) begin
            $display("checker: result with nothing outstanding: %h", out_item_i);
          end
        end else begin
          want = cursor_reports_q.pop_front();
          if (out_item_i.cell_data !== want.cell_data ||
              out_item_i.cursor_row !== want.cursor_row ||
              out_item_i.cursor_col !== want.cursor_col ||
              out_item_i.cursor_linear !== want.cursor_linear) begin
            note_failure();
            if (fail_count <= REPORT_LIMIT) begin
              $display({"checker: mismatch (exp/got) cell %h/%h row %0d/%0d",
                        " col %0d/%0d lin %0d/%0d"},
                       want.cell_data, out_item_i.cell_data,
                       want.cursor_row, out_item_i.cursor_row,
                       want.cursor_col, out_item_i.cursor_col,
                       want.cursor_linear, out_item_i.cursor_linear);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        cursor_reports_q.push_back(apply_console_request(in_item_i));
      end
    end
    failures_o <= fail_count;
    pending_o  <= cursor_reports_q.size();
  end

endmodule

// ===== tb/text_console_char_engine_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine_tb: request stimulus and verdict for the console
// directed puts, controls, reads and clears first, then phases of random
// text with reads, each phase under its own attribute write; bursty sender,
// stalling receiver with one long hold-off, checking done by the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_char_engine_tb;
  import tcce_pkg::*;

  // command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int IDLE_LIMIT    = 20000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int PHASE_LENGTH  = 300;    // random requests per attribute phase
  localparam int SETTLE_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  tcce_in_t          in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tcce_out_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;

  int failures;
  int pending;
  int burst_left = 0;
  int idle_cycles = 0;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  text_console_char_engine u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  text_console_char_engine_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  // offer one request; the sender works in bursts with idle gaps between
  task automatic send_request(input tcce_in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // a quarter of the bursts follow on with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  function automatic tcce_in_t make_request(input logic [CMD_W-1:0] cmd,
                                            input logic [CHAR_W-1:0] ch,
                                            input int row, input int col);
    tcce_in_t r;
    r.command   = cmd;
    r.char_code = ch;
    r.read_row  = RROW_W'(row);
    r.read_col  = RCOL_W'(col);
    return r;
  endfunction

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    send_request(make_request(CMD_PUT, ch, 0, 0));
  endtask

  task automatic send_read(input int row, input int col);
    send_request(make_request(CMD_READ, CH_SPACE, row, col));
  endtask

  // stop offering and wait for every outstanding result to come back
  task automatic drain_requests();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // attribute register write, only issued with nothing in flight
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly running text with line controls and reads, some noise
  function automatic tcce_in_t random_request();
    tcce_in_t r;
    int pick;
    r.command   = CMD_PUT;
    r.char_code = CHAR_W'($urandom);
    r.read_row  = RROW_W'($urandom);
    r.read_col  = RCOL_W'($urandom);
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      r.command = CMD_CLEAR;
    end else if (pick < 20) begin
      r.command = CMD_UNUSED;
    end else if (pick < 220) begin
      r.command = CMD_READ;
      // most reads land on the screen, the rest anywhere in the field range
      if ($urandom_range(0, 9) != 0) begin
        r.read_row = RROW_W'($urandom_range(0, SCREEN_ROWS - 1));
        r.read_col = RCOL_W'($urandom_range(0, SCREEN_COLS - 1));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      r.char_code = CHAR_W'($urandom_range(8'h20, 8'h7E));
      else if (pick < 62) r.char_code = CHAR_W'($urandom_range(8'h80, 8'hFF));
      else if (pick < 72) r.char_code = CH_LF;
      else if (pick < 77) r.char_code = CH_CR;
      else if (pick < 83) r.char_code = CH_TAB;
      else if (pick < 92) r.char_code = CH_BS;
      else                r.char_code = CHAR_W'($urandom_range(0, 8'h1F));
    end
    return r;
  endfunction

  // receiver: stall patterns of random length, one long hold-off on request
  initial begin
    int mode;
    int len;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // block fills up behind this and has to stall its request side
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 150);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= i[1];
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles in which no handshake happens
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [6];
    phase_attr[0] = 8'hFF;
    phase_attr[1] = 8'h00;
    phase_attr[2] = ATTR_W'($urandom);
    phase_attr[3] = ATTR_RESET;
    phase_attr[4] = ATTR_W'($urandom);
    phase_attr[5] = 8'h70;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset attribute; clear first so no read
    // ever touches a cell that was never written
    send_request(make_request(CMD_CLEAR, 8'h00, 0, 0));
    send_put(CH_BS);               // backspace at home stays put
    send_read(0, 0);
    send_put(8'h41);
    send_put(8'hFF);
    send_put(8'h00);               // other control bytes leave the screen alone
    send_put(8'h1F);
    send_put(CH_BS);               // step back and blank
    send_put(CH_TAB);
    send_put(CH_LF);
    send_put(CH_BS);               // column 0 backs onto column 80 of the row above
    send_put(8'h7E);               // printable at column 80 lands on the next row
    send_put(CH_BS);
    send_put(8'h01);               // ignored byte still wraps from column 80
    send_put(CH_TAB);
    send_read(1, 0);
    send_read(31, 127);            // out of range both ways
    send_read(24, 79);
    send_read(0, 80);
    send_request(make_request(CMD_UNUSED, 8'hA5, 31, 127));
    for (int i = 0; i < 10; i++) begin
      send_put(CH_TAB);            // tabs run into the last column and wrap
    end
    send_put(CH_CR);
    drain_requests();

    write_attribute(8'hF0);
    send_put(8'h5A);
    send_read(1, 0);
    drain_requests();

    // random part in phases, attribute changed between them while idle
    hold_req <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      write_attribute(phase_attr[p]);
      for (int n = 0; n < PHASE_LENGTH; n++) begin
        send_request(random_request());
      end
      drain_requests();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_ctrl.sv
rtl/tcce_dp.sv
rtl/text_console_char_engine.sv
tb/text_console_char_engine_checker.sv
tb/text_console_char_engine_tb.sv
